@@ src/kcse_pkg.sv @@
// Package for the chunk size estimator: item and result structs, codes,
// state encodings and the interface of the shared arithmetic unit.
// No dependencies; imported by kcse_iter_unit and the top level.
package kcse_pkg;

    // Fixed-point constants (Q16.16 cost, Q32.16 variance).
    localparam logic [31:0] C_EPS_Q         = 32'd66;
    localparam logic [63:0] C_MAX_CHUNK     = 64'd16777216;
    localparam logic [63:0] C_OUT_CHUNK_MAX = 64'h1FF_FFFF;
    localparam logic [47:0] C_VAR_MAX       = 48'hFFFF_FFFF_FFFF;
    localparam logic [16:0] C_ONE_Q16       = 17'd65536;
    localparam logic [13:0] C_DIV10_RECIP   = 14'd6554;
    localparam logic [31:0] C_PCT_SAT_TIME  = 32'd995;
    localparam logic [6:0]  C_PCT_MAX       = 7'd100;
    localparam logic [6:0]  C_PCT_MIN       = 7'd1;

    // Register reset values.
    localparam logic [19:0] C_RST_TARGET_TIME    = 20'd200;
    localparam logic [31:0] C_RST_DRIFT_NOISE    = 32'd3277;
    localparam logic [31:0] C_RST_TIMER_SIGMA    = 32'd131072;
    localparam logic [31:0] C_RST_ITEM_SIGMA     = 32'd0;
    localparam logic [31:0] C_RST_PESSIMISM_GAIN = 32'd98304;
    localparam logic [31:0] C_RST_OUTLIER_GATE   = 32'd196608;
    localparam logic [31:0] C_RST_YIELD_NOISE    = 32'd32768;
    localparam logic [24:0] C_RST_LEAST_CHUNK    = 25'd1;

    typedef enum logic [1:0] {
        FN_RESTART,
        FN_QUERY,
        FN_DONE,
        FN_YIELD
    } t_func;

    typedef enum logic [2:0] {
        REG_TARGET_TIME,
        REG_DRIFT_NOISE,
        REG_TIMER_SIGMA,
        REG_ITEM_SIGMA,
        REG_PESSIMISM_GAIN,
        REG_OUTLIER_GATE,
        REG_YIELD_NOISE,
        REG_LEAST_CHUNK
    } t_reg_idx;

    typedef struct packed {
        t_func       func;
        logic [31:0] cost_guess;
        logic [31:0] items_left;
        logic [24:0] chunk_items;
        logic [31:0] elapsed_time;
    } t_in_item;

    typedef struct packed {
        logic [24:0] chunk_size;
        logic [6:0]  slice_percent;
        logic        rejected;
        logic [31:0] cost_estimate;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_unit_op;

    typedef struct packed {
        logic        start;
        t_unit_op    op;
        logic [63:0] a;
        logic [63:0] b;
    } t_unit_req;

    typedef struct packed {
        logic        done;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_unit_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RS_MUL,
        ST_Q_SQRT,
        ST_Q_MUL,
        ST_Q_DIV,
        ST_D_Z,
        ST_D_TT,
        ST_D_NN,
        ST_D_R1,
        ST_D_II,
        ST_D_R2,
        ST_D_L,
        ST_D_G,
        ST_D_RH,
        ST_D_K,
        ST_D_DL,
        ST_D_V,
        ST_OUT
    } t_state;

endpackage

@@ src/kcse_iter_unit.sv @@
// Shared iterative arithmetic unit: 64x64 multiply, 64/64 divide and
// 64-bit integer square root, one bit or digit per cycle. Uses kcse_pkg.
module kcse_iter_unit
    import kcse_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    t_unit_op    r_op, n_op;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_a, n_a;
    logic [63:0] r_hi, n_hi;
    logic [63:0] r_lo, n_lo;

    logic [64:0] s_x, s_y;
    logic        s_sub;
    logic [65:0] s_res;
    logic        s_ge;

    // One shared adder/subtractor; operands depend on the operation.
    always_comb begin
        case (r_op)
            OP_MUL: begin
                s_x   = {1'b0, r_hi};
                s_y   = r_lo[0] ? {1'b0, r_a} : '0;
                s_sub = 1'b0;
            end
            OP_DIV: begin
                s_x   = {r_hi, r_lo[63]};
                s_y   = {1'b0, r_a};
                s_sub = 1'b1;
            end
            OP_SQRT: begin
                s_x   = {r_hi[62:0], r_lo[63:62]};
                s_y   = {r_a[62:0], 2'b01};
                s_sub = 1'b1;
            end
            default: begin
                s_x   = '0;
                s_y   = '0;
                s_sub = 1'b0;
            end
        endcase
        s_res = {1'b0, s_x} + ({1'b0, s_y} ^ {66{s_sub}}) + {65'd0, s_sub};
        s_ge  = ~s_res[65];
    end

    // Load on start, then one step per cycle until the count runs out.
    // The partial remainder stays below the divisor (or 2*root + 1), so it
    // always fits in 64 bits.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_hi   = r_hi;
        n_lo   = r_lo;
        if (!r_busy) begin
            if (i_req.start) begin
                n_busy = 1'b1;
                n_op   = i_req.op;
                n_cnt  = (i_req.op == OP_SQRT) ? 6'd31 : 6'd63;
                n_hi   = '0;
                case (i_req.op)
                    OP_MUL: begin
                        n_a  = i_req.a;
                        n_lo = i_req.b;
                    end
                    OP_DIV: begin
                        n_a  = i_req.b;
                        n_lo = i_req.a;
                    end
                    default: begin
                        n_a  = '0;
                        n_lo = i_req.a;
                    end
                endcase
            end
        end else begin
            case (r_op)
                OP_MUL: begin
                    n_hi = s_res[64:1];
                    n_lo = {s_res[0], r_lo[63:1]};
                end
                OP_DIV: begin
                    n_hi = s_ge ? s_res[63:0] : s_x[63:0];
                    n_lo = {r_lo[62:0], s_ge};
                end
                default: begin
                    n_hi = s_ge ? s_res[63:0] : s_x[63:0];
                    n_lo = {r_lo[61:0], 2'b00};
                    n_a  = {r_a[62:0], s_ge};
                end
            endcase
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
        end
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_hi  <= n_hi;
        r_lo  <= n_lo;
    end

    // Result is valid in the cycle that done is high.
    assign o_rsp.done = r_done;
    assign o_rsp.hi   = r_hi;
    assign o_rsp.lo   = (r_op == OP_SQRT) ? r_a : r_lo;

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("unit started while busy");

    a_busy_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt != '0) |=> r_busy)
        else $error("unit stopped before its last step");

    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0) |=> (r_done && !r_busy))
        else $error("unit did not finish after its last step");

endmodule

@@ src/kalman_chunk_size_estimator_top.sv @@
// Top level of the Kalman chunk size estimator: handshakes, configuration
// registers, filter state and the sequencer. Uses kcse_pkg, kcse_iter_unit.
//
// One item is worked at a time through a single shared unit that multiplies
// or divides in 64 steps plus issue and handoff, and takes square roots. A
// finished chunk runs the outlier test when the measurement lies above the
// estimate, and a zero chunk_items goes straight to the output. The input
// is not ready until the result has been placed in the output register,
// which holds it while the next item enters.
module kalman_chunk_size_estimator_top
    import kcse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // Configuration registers.
    logic [19:0] r_target_time;
    logic [31:0] r_drift_noise, r_timer_sigma, r_item_sigma;
    logic [31:0] r_pessimism_gain, r_outlier_gate, r_yield_noise;
    logic [24:0] r_least_chunk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_time    <= C_RST_TARGET_TIME;
            r_drift_noise    <= C_RST_DRIFT_NOISE;
            r_timer_sigma    <= C_RST_TIMER_SIGMA;
            r_item_sigma     <= C_RST_ITEM_SIGMA;
            r_pessimism_gain <= C_RST_PESSIMISM_GAIN;
            r_outlier_gate   <= C_RST_OUTLIER_GATE;
            r_yield_noise    <= C_RST_YIELD_NOISE;
            r_least_chunk    <= C_RST_LEAST_CHUNK;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_TARGET_TIME:    r_target_time    <= i_cfg_data[19:0];
                REG_DRIFT_NOISE:    r_drift_noise    <= i_cfg_data;
                REG_TIMER_SIGMA:    r_timer_sigma    <= i_cfg_data;
                REG_ITEM_SIGMA:     r_item_sigma     <= i_cfg_data;
                REG_PESSIMISM_GAIN: r_pessimism_gain <= i_cfg_data;
                REG_OUTLIER_GATE:   r_outlier_gate   <= i_cfg_data;
                REG_YIELD_NOISE:    r_yield_noise    <= i_cfg_data;
                REG_LEAST_CHUNK:    r_least_chunk    <= i_cfg_data[24:0];
                default:            r_least_chunk    <= r_least_chunk;
            endcase
        end
    end

    // Sequencer state, filter state and working registers.
    t_state      r_state, n_state;
    logic        r_issued, n_issued;
    t_in_item    r_in, n_in;
    logic [31:0] r_cost, n_cost;
    logic [47:0] r_var, n_var;
    logic [47:0] r_p, n_p;
    logic [48:0] r_r, n_r;
    logic [49:0] r_s, n_s;
    logic [49:0] r_nn, n_nn;
    logic [63:0] r_tmp, n_tmp;
    logic [48:0] r_mag, n_mag;
    logic        r_pos, n_pos;
    logic        r_neg, n_neg;
    logic [16:0] r_k, n_k;
    logic [95:0] r_lhs, n_lhs;
    logic [24:0] r_chunk, n_chunk;
    logic        r_rej, n_rej;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    t_unit_req   s_req;
    t_unit_rsp   s_rsp;

    kcse_iter_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_req),
        .o_rsp   (s_rsp)
    );

    // Helper terms.
    logic [31:0]  s_g;
    logic [64:0]  s_rs_sum;
    logic [48:0]  s_var_drift, s_var_yield;
    logic [48:0]  s_pess;
    logic [63:0]  s_n1, s_n2, s_n3;
    logic [48:0]  s_z, s_cost_w, s_delta, s_x;
    logic [48:0]  s_r_sum;
    logic [127:0] s_lhs_w;
    logic [9:0]   s_pct_in;
    logic [23:0]  s_pct_prod;
    logic [6:0]   s_pct;
    logic         s_slot_free;

    always_comb begin
        s_g         = (r_in.cost_guess < C_EPS_Q) ? C_EPS_Q : r_in.cost_guess;
        s_rs_sum    = {1'b0, s_rsp.lo} + 65'h2_0000;
        s_var_drift = {1'b0, r_var} + {17'd0, r_drift_noise};
        s_var_yield = {1'b0, r_var} + {17'd0, r_yield_noise};
        s_pess      = {17'd0, r_cost} + {1'b0, s_rsp.lo[63:16]};
        if (s_pess < {17'd0, C_EPS_Q}) begin
            s_pess = {17'd0, C_EPS_Q};
        end
        // Chunk clamps in order: least, max, items left, output width.
        if (s_rsp.lo < {39'd0, r_least_chunk}) begin
            s_n1 = {39'd0, r_least_chunk};
        end else if (s_rsp.lo > C_MAX_CHUNK) begin
            s_n1 = C_MAX_CHUNK;
        end else begin
            s_n1 = s_rsp.lo;
        end
        s_n2 = (s_n1 > {32'd0, r_in.items_left}) ? {32'd0, r_in.items_left} : s_n1;
        s_n3 = (s_n2 > C_OUT_CHUNK_MAX) ? C_OUT_CHUNK_MAX : s_n2;
        s_z      = s_rsp.lo[48:0];
        s_cost_w = {17'd0, r_cost};
        s_delta  = {1'b0, s_rsp.lo[63:16]};
        // Corrected cost, floored at epsilon and saturated at 32 bits.
        if (r_pos) begin
            s_x = s_cost_w + s_delta;
        end else if (r_neg) begin
            s_x = (s_delta >= s_cost_w) ? '0 : s_cost_w - s_delta;
        end else begin
            s_x = s_cost_w;
        end
        if (s_x < {17'd0, C_EPS_Q}) begin
            s_x = {17'd0, C_EPS_Q};
        end else if (s_x[48:32] != '0) begin
            s_x = {17'd0, 32'hFFFF_FFFF};
        end
        s_r_sum = r_r + {1'b0, s_rsp.lo[63:16]};
        s_lhs_w = {16'd0, r_lhs, 16'd0};
        // Rounded percent by reciprocal multiply; saturates above 994 us.
        s_pct_in   = r_in.elapsed_time[9:0] + 10'd5;
        s_pct_prod = {14'd0, s_pct_in} * {10'd0, C_DIV10_RECIP};
        if (r_in.elapsed_time >= C_PCT_SAT_TIME) begin
            s_pct = C_PCT_MAX;
        end else if (s_pct_prod[22:16] == '0) begin
            s_pct = C_PCT_MIN;
        end else begin
            s_pct = s_pct_prod[22:16];
        end
        s_slot_free = !r_out_valid || i_out_ready;
    end

    // Next state, unit requests and working register updates.
    always_comb begin
        n_state     = r_state;
        n_issued    = r_issued;
        n_in        = r_in;
        n_cost      = r_cost;
        n_var       = r_var;
        n_p         = r_p;
        n_r         = r_r;
        n_s         = r_s;
        n_nn        = r_nn;
        n_tmp       = r_tmp;
        n_mag       = r_mag;
        n_pos       = r_pos;
        n_neg       = r_neg;
        n_k         = r_k;
        n_lhs       = r_lhs;
        n_chunk     = r_chunk;
        n_rej       = r_rej;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        s_req.start = 1'b0;
        s_req.op    = OP_MUL;
        s_req.a     = '0;
        s_req.b     = '0;
        o_in_ready  = (r_state == ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_item;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_chunk = '0;
                n_rej   = 1'b0;
                case (r_in.func)
                    FN_RESTART: n_state = ST_RS_MUL;
                    FN_QUERY:   n_state = (r_in.items_left == '0) ? ST_OUT : ST_Q_SQRT;
                    FN_DONE: begin
                        n_p     = s_var_drift[48] ? C_VAR_MAX : s_var_drift[47:0];
                        n_state = (r_in.chunk_items == '0) ? ST_OUT : ST_D_Z;
                    end
                    default: begin
                        n_var   = s_var_yield[48] ? C_VAR_MAX : s_var_yield[47:0];
                        n_state = ST_OUT;
                    end
                endcase
            end
            // Restart: variance is (guess/2)^2 rounded.
            ST_RS_MUL: begin
                s_req.start = !r_issued;
                s_req.a     = {32'd0, s_g};
                s_req.b     = {32'd0, s_g};
                if (s_rsp.done) begin
                    n_cost  = s_g;
                    n_var   = {1'b0, s_rs_sum[64:18]};
                    n_state = ST_OUT;
                end
            end
            // Query: sd, pessimistic cost, then target over it.
            ST_Q_SQRT: begin
                s_req.start = !r_issued;
                s_req.op    = OP_SQRT;
                s_req.a     = {r_var, 16'd0};
                if (s_rsp.done) begin
                    n_tmp   = {32'd0, s_rsp.lo[31:0]};
                    n_state = ST_Q_MUL;
                end
            end
            ST_Q_MUL: begin
                s_req.start = !r_issued;
                s_req.a     = {32'd0, r_pessimism_gain};
                s_req.b     = r_tmp;
                if (s_rsp.done) begin
                    n_tmp   = {15'd0, s_pess};
                    n_state = ST_Q_DIV;
                end
            end
            ST_Q_DIV: begin
                s_req.start = !r_issued;
                s_req.op    = OP_DIV;
                s_req.a     = {28'd0, r_target_time, 16'd0};
                s_req.b     = r_tmp;
                if (s_rsp.done) begin
                    n_chunk = s_n3[24:0];
                    n_state = ST_OUT;
                end
            end
            // Finished chunk: measured cost and innovation.
            ST_D_Z: begin
                s_req.start = !r_issued;
                s_req.op    = OP_DIV;
                s_req.a     = {16'd0, r_in.elapsed_time, 16'd0}
                            + {40'd0, r_in.chunk_items[24:1]};
                s_req.b     = {39'd0, r_in.chunk_items};
                if (s_rsp.done) begin
                    n_pos   = s_z > s_cost_w;
                    n_neg   = s_z < s_cost_w;
                    n_mag   = (s_z > s_cost_w) ? s_z - s_cost_w : s_cost_w - s_z;
                    n_state = ST_D_TT;
                end
            end
            // Measurement noise R = ts^2/n^2 + is^2/n.
            ST_D_TT: begin
                s_req.start = !r_issued;
                s_req.a     = {32'd0, r_timer_sigma};
                s_req.b     = {32'd0, r_timer_sigma};
                if (s_rsp.done) begin
                    n_tmp   = s_rsp.lo;
                    n_state = ST_D_NN;
                end
            end
            ST_D_NN: begin
                s_req.start = !r_issued;
                s_req.a     = {39'd0, r_in.chunk_items};
                s_req.b     = {39'd0, r_in.chunk_items};
                if (s_rsp.done) begin
                    n_nn    = s_rsp.lo[49:0];
                    n_state = ST_D_R1;
                end
            end
            ST_D_R1: begin
                s_req.start = !r_issued;
                s_req.op    = OP_DIV;
                s_req.a     = r_tmp;
                s_req.b     = {14'd0, r_nn};
                if (s_rsp.done) begin
                    n_r     = {1'b0, s_rsp.lo[63:16]};
                    n_state = ST_D_II;
                end
            end
            ST_D_II: begin
                s_req.start = !r_issued;
                s_req.a     = {32'd0, r_item_sigma};
                s_req.b     = {32'd0, r_item_sigma};
                if (s_rsp.done) begin
                    n_tmp   = s_rsp.lo;
                    n_state = ST_D_R2;
                end
            end
            ST_D_R2: begin
                s_req.start = !r_issued;
                s_req.op    = OP_DIV;
                s_req.a     = r_tmp;
                s_req.b     = {39'd0, r_in.chunk_items};
                if (s_rsp.done) begin
                    n_r     = s_r_sum;
                    n_s     = {2'd0, r_p} + {1'b0, s_r_sum};
                    n_state = r_pos ? ST_D_L : ST_D_K;
                end
            end
            // Outlier test: mag^2 * 2^16 against gate^2 * (P + R).
            ST_D_L: begin
                s_req.start = !r_issued;
                s_req.a     = {15'd0, r_mag};
                s_req.b     = {15'd0, r_mag};
                if (s_rsp.done) begin
                    n_lhs   = {s_rsp.hi[31:0], s_rsp.lo};
                    n_state = ST_D_G;
                end
            end
            ST_D_G: begin
                s_req.start = !r_issued;
                s_req.a     = {32'd0, r_outlier_gate};
                s_req.b     = {32'd0, r_outlier_gate};
                if (s_rsp.done) begin
                    n_tmp   = s_rsp.lo;
                    n_state = ST_D_RH;
                end
            end
            ST_D_RH: begin
                s_req.start = !r_issued;
                s_req.a     = r_tmp;
                s_req.b     = {14'd0, r_s};
                if (s_rsp.done) begin
                    if (s_lhs_w > {s_rsp.hi, s_rsp.lo}) begin
                        n_var   = r_p;
                        n_rej   = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_D_K;
                    end
                end
            end
            // Gain K = P / (P + R) in Q1.16.
            ST_D_K: begin
                if (r_s == '0) begin
                    n_k     = '0;
                    n_state = ST_D_DL;
                end else begin
                    s_req.start = !r_issued;
                    s_req.op    = OP_DIV;
                    s_req.a     = {r_p, 16'd0};
                    s_req.b     = {14'd0, r_s};
                    if (s_rsp.done) begin
                        n_k     = s_rsp.lo[16:0];
                        n_state = ST_D_DL;
                    end
                end
            end
            ST_D_DL: begin
                s_req.start = !r_issued;
                s_req.a     = {47'd0, r_k};
                s_req.b     = {15'd0, r_mag};
                if (s_rsp.done) begin
                    n_cost  = s_x[31:0];
                    n_state = ST_D_V;
                end
            end
            ST_D_V: begin
                s_req.start = !r_issued;
                s_req.a     = {47'd0, C_ONE_Q16 - r_k};
                s_req.b     = {16'd0, r_p};
                if (s_rsp.done) begin
                    n_var   = s_rsp.lo[63:16];
                    n_state = ST_OUT;
                end
            end
            // Place the result once the output register is free.
            ST_OUT: begin
                if (s_slot_free) begin
                    n_out.chunk_size    = r_chunk;
                    n_out.slice_percent = (r_in.func == FN_DONE) ? s_pct : '0;
                    n_out.rejected      = r_rej;
                    n_out.cost_estimate = r_cost;
                    n_out_valid         = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (s_req.start) begin
            n_issued = 1'b1;
        end
        if (s_rsp.done) begin
            n_issued = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cost      <= C_EPS_Q;
            r_var       <= '0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            r_cost      <= n_cost;
            r_var       <= n_var;
        end
        r_in    <= n_in;
        r_p     <= n_p;
        r_r     <= n_r;
        r_s     <= n_s;
        r_nn    <= n_nn;
        r_tmp   <= n_tmp;
        r_mag   <= n_mag;
        r_pos   <= n_pos;
        r_neg   <= n_neg;
        r_k     <= n_k;
        r_lhs   <= n_lhs;
        r_chunk <= n_chunk;
        r_rej   <= n_rej;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a beat was taken");

    a_reject_has_percent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.rejected) |-> (o_out_item.slice_percent != '0))
        else $error("rejected result without a slice percent");

    a_chunk_excludes_percent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.chunk_size != '0) |-> (o_out_item.slice_percent == '0))
        else $error("chunk size and slice percent both set");

endmodule
